/* design/dcpu_pkg.sv */
// Package for the DCPU-style execute unit: opcodes, state encoding, control struct.
// No dependencies.
package dcpu_pkg;
	localparam int unsigned DataWidth = 16;
	localparam int unsigned OpWidth = 5;

	localparam logic [OpWidth-1:0] OP_SET = 5'h01;
	localparam logic [OpWidth-1:0] OP_ADD = 5'h02;
	localparam logic [OpWidth-1:0] OP_SUB = 5'h03;
	localparam logic [OpWidth-1:0] OP_MUL = 5'h04;
	localparam logic [OpWidth-1:0] OP_MLI = 5'h05;
	localparam logic [OpWidth-1:0] OP_DIV = 5'h06;
	localparam logic [OpWidth-1:0] OP_DVI = 5'h07;
	localparam logic [OpWidth-1:0] OP_MOD = 5'h08;
	localparam logic [OpWidth-1:0] OP_MDI = 5'h09;
	localparam logic [OpWidth-1:0] OP_AND = 5'h0A;
	localparam logic [OpWidth-1:0] OP_BOR = 5'h0B;
	localparam logic [OpWidth-1:0] OP_XOR = 5'h0C;
	localparam logic [OpWidth-1:0] OP_SHR = 5'h0D;
	localparam logic [OpWidth-1:0] OP_ASR = 5'h0E;
	localparam logic [OpWidth-1:0] OP_SHL = 5'h0F;
	localparam logic [OpWidth-1:0] OP_IFB = 5'h10;
	localparam logic [OpWidth-1:0] OP_IFC = 5'h11;
	localparam logic [OpWidth-1:0] OP_IFE = 5'h12;
	localparam logic [OpWidth-1:0] OP_IFN = 5'h13;
	localparam logic [OpWidth-1:0] OP_IFG = 5'h14;
	localparam logic [OpWidth-1:0] OP_IFA = 5'h15;
	localparam logic [OpWidth-1:0] OP_IFL = 5'h16;
	localparam logic [OpWidth-1:0] OP_IFU = 5'h17;
	localparam logic [OpWidth-1:0] OP_STI = 5'h1E;
	localparam logic [OpWidth-1:0] OP_STD = 5'h1F;

	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_INC = 2'd1;
	localparam logic [1:0] STEP_DEC = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	// start request and completion report between top level and divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;
endpackage

/* design/dcpu_if.sv */
// Valid/ready channel carrying one item.
// Depends on nothing; payload type is a parameter.
interface dcpu_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/dcpu16_execute_unit_top.sv */
// DCPU-style execute unit (dcpu_pkg, dcpu_if, dcpu_div): ALU ops, IF tests, skip chaining.
// The result is registered in out_valid_q after the item passes through run_q; DIV/DVI/MOD/MDI with a
// nonzero divisor instead run the shared 32-step divider and then pass through DONE.
// One item at a time; the next is taken no earlier than the cycle after the result is taken,
// since in_ch.ready stays low while an item is worked on or its result waits.
// Reset (arst_n, asynchronous): EX and the skip flag clear, channels idle.
module dcpu16_execute_unit_top (
	input logic clk,
	input logic arst_n,
	dcpu_if.sink   in_ch,
	dcpu_if.source out_ch
);
	localparam int unsigned W = dcpu_pkg::DataWidth;

	dcpu_pkg::state_t state_q, state_d;
	logic [4:0]   op_q;
	logic [W-1:0] b_q, a_q;
	logic [W-1:0] ex_q;
	logic         skip_q;
	logic         out_valid_q;
	logic [W-1:0] nb_q, exo_q;
	logic         wr_q, skd_q;
	logic [1:0]   step_q;

	// divider operands: magnitudes; for DIV/DVI b sits in the high half so the low
	// quotient half gives EX, for MOD/MDI b sits in the low half for a plain remainder
	logic        is_sdiv, neg_b, neg_a, neg_q;
	logic [W-1:0] mag_b, mag_a;
	logic         div_start;
	logic [31:0]  quo;
	logic [W-1:0] rem;
	dcpu_pkg::div_ctrl_t dctl;
	logic is_mod;

	assign is_mod = (op_q == dcpu_pkg::OP_MOD) || (op_q == dcpu_pkg::OP_MDI);
	assign is_sdiv = (op_q == dcpu_pkg::OP_DVI) || (op_q == dcpu_pkg::OP_MDI);
	assign neg_b = is_sdiv & b_q[W-1];
	assign neg_a = is_sdiv & a_q[W-1];
	assign neg_q = neg_b ^ neg_a;
	assign mag_b = neg_b ? (~b_q + 1'b1) : b_q;
	assign mag_a = neg_a ? (~a_q + 1'b1) : a_q;

	dcpu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(is_mod ? {{W{1'b0}}, mag_b} : {mag_b, {W{1'b0}}}), .divisor(mag_a),
		.ctrl(dctl), .quotient(quo), .remainder(rem)
	);

	// combinational results of the non-divide ops
	logic [W-1:0] c_nb, c_ex;
	logic         c_wr, c_ex_wr, c_skip;
	logic [1:0]   c_step;
	logic [W:0]   sum, dif;
	logic [31:0]  prod, sprod, shr_r, asr_r, shl_r;
	logic [5:0]   sh;
	logic         is_if;

	assign sum = {1'b0, b_q} + {1'b0, a_q};
	assign dif = {1'b0, b_q} - {1'b0, a_q};
	assign prod = b_q * a_q;
	assign sprod = $signed(b_q) * $signed(a_q);
	assign sh = (a_q > 16'd32) ? 6'd32 : a_q[5:0];
	assign shr_r = {b_q, {W{1'b0}}} >> sh;
	assign asr_r = $signed({b_q, {W{1'b0}}}) >>> sh;
	assign shl_r = {{W{1'b0}}, b_q} << sh;
	assign is_if = (op_q[4:3] == 2'b10);

	always_comb begin
		c_nb = b_q;
		c_wr = 1'b0;
		c_ex = ex_q;
		c_ex_wr = 1'b0;
		c_step = dcpu_pkg::STEP_NONE;
		c_skip = 1'b0;
		case (op_q)
			dcpu_pkg::OP_SET: begin c_nb = a_q; c_wr = 1'b1; end
			dcpu_pkg::OP_ADD: begin
				c_nb = sum[W-1:0]; c_wr = 1'b1; c_ex_wr = 1'b1;
				c_ex = {{(W-1){1'b0}}, sum[W]};
			end
			dcpu_pkg::OP_SUB: begin
				c_nb = dif[W-1:0]; c_wr = 1'b1; c_ex_wr = 1'b1;
				c_ex = {W{dif[W]}};
			end
			dcpu_pkg::OP_MUL: begin
				c_nb = prod[15:0]; c_wr = 1'b1; c_ex_wr = 1'b1; c_ex = prod[31:16];
			end
			dcpu_pkg::OP_MLI: begin
				c_nb = sprod[15:0]; c_wr = 1'b1; c_ex_wr = 1'b1; c_ex = sprod[31:16];
			end
			dcpu_pkg::OP_AND: begin c_nb = b_q & a_q; c_wr = 1'b1; end
			dcpu_pkg::OP_BOR: begin c_nb = b_q | a_q; c_wr = 1'b1; end
			dcpu_pkg::OP_XOR: begin c_nb = b_q ^ a_q; c_wr = 1'b1; end
			dcpu_pkg::OP_SHR: begin
				c_nb = shr_r[31:16]; c_wr = 1'b1; c_ex_wr = 1'b1; c_ex = shr_r[15:0];
			end
			dcpu_pkg::OP_ASR: begin
				c_nb = asr_r[31:16]; c_wr = 1'b1; c_ex_wr = 1'b1; c_ex = asr_r[15:0];
			end
			dcpu_pkg::OP_SHL: begin
				c_nb = shl_r[15:0]; c_wr = 1'b1; c_ex_wr = 1'b1; c_ex = shl_r[31:16];
			end
			dcpu_pkg::OP_IFB: c_skip = ((b_q & a_q) == '0);
			dcpu_pkg::OP_IFC: c_skip = ((b_q & a_q) != '0);
			dcpu_pkg::OP_IFE: c_skip = (b_q != a_q);
			dcpu_pkg::OP_IFN: c_skip = (b_q == a_q);
			dcpu_pkg::OP_IFG: c_skip = !(b_q > a_q);
			dcpu_pkg::OP_IFA: c_skip = !($signed(b_q) > $signed(a_q));
			dcpu_pkg::OP_IFL: c_skip = !(b_q < a_q);
			dcpu_pkg::OP_IFU: c_skip = !($signed(b_q) < $signed(a_q));
			dcpu_pkg::OP_STI: begin c_nb = a_q; c_wr = 1'b1; c_step = dcpu_pkg::STEP_INC; end
			dcpu_pkg::OP_STD: begin c_nb = a_q; c_wr = 1'b1; c_step = dcpu_pkg::STEP_DEC; end
			default: ;
		endcase
	end

	// divide results: quotient high half is b/a, low half gives EX; negate the
	// high half on its own so the signed quotient truncates toward zero
	logic [31:0] squo;
	logic [W-1:0] sq_hi;
	logic [W-1:0] srem;
	assign squo = neg_q ? (~quo + 1'b1) : quo;
	assign sq_hi = neg_q ? (~quo[31:16] + 1'b1) : quo[31:16];
	assign srem = neg_b ? (~rem + 1'b1) : rem;

	logic is_div_op;
	assign is_div_op = (op_q == dcpu_pkg::OP_DIV) || (op_q == dcpu_pkg::OP_DVI) || is_mod;

	// sequencer: IDLE takes an item and finishes anything but a live divide;
	// DIV waits on the divider; DONE registers the divide result and returns to IDLE
	logic       load;
	logic       fin_simple;
	logic       run_q;
	// hold off new items while one is being worked on or its result waits
	assign in_ch.ready = (state_q == dcpu_pkg::ST_IDLE) && !out_valid_q && !run_q;
	assign load = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		fin_simple = 1'b0;
		case (state_q)
			dcpu_pkg::ST_IDLE: begin
				if (run_q) begin
					if (!skip_q && is_div_op && a_q != '0) begin
						div_start = 1'b1;
						state_d = dcpu_pkg::ST_DIV;
					end else begin
						fin_simple = 1'b1;
					end
				end
			end
			dcpu_pkg::ST_DIV: if (dctl.done) state_d = dcpu_pkg::ST_DONE;
			dcpu_pkg::ST_DONE: state_d = dcpu_pkg::ST_IDLE;
			default: state_d = dcpu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcpu_pkg::ST_IDLE;
			run_q <= 1'b0;
			out_valid_q <= 1'b0;
			ex_q <= '0;
			skip_q <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q <= load;
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			if (fin_simple) begin
				out_valid_q <= 1'b1;
				if (skip_q) begin
					skip_q <= is_if;
				end else begin
					skip_q <= c_skip;
					if (c_ex_wr) ex_q <= c_ex;
				end
			end else if (state_q == dcpu_pkg::ST_DONE) begin
				out_valid_q <= 1'b1;
				if (!is_mod) ex_q <= squo[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q <= in_ch.data.opcode;
			b_q <= in_ch.data.b_value;
			a_q <= in_ch.data.a_value;
		end
		if (fin_simple) begin
			skd_q <= skip_q;
			if (skip_q) begin
				nb_q <= b_q; wr_q <= 1'b0; step_q <= dcpu_pkg::STEP_NONE; exo_q <= ex_q;
			end else if (is_div_op) begin
				// zero divisor: b gets 0, EX holds
				nb_q <= '0; wr_q <= 1'b1; step_q <= dcpu_pkg::STEP_NONE; exo_q <= ex_q;
			end else begin
				nb_q <= c_wr ? c_nb : b_q; wr_q <= c_wr; step_q <= c_step;
				exo_q <= c_ex_wr ? c_ex : ex_q;
			end
		end else if (state_q == dcpu_pkg::ST_DONE) begin
			skd_q <= 1'b0; wr_q <= 1'b1; step_q <= dcpu_pkg::STEP_NONE;
			nb_q <= is_mod ? srem : sq_hi;
			exo_q <= is_mod ? ex_q : squo[15:0];
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data.new_b = nb_q;
	assign out_ch.data.write_b = wr_q;
	assign out_ch.data.ex_out = exo_q;
	assign out_ch.data.index_step = step_q;
	assign out_ch.data.was_skipped = skd_q;
endmodule

/* design/dcpu_div.sv */
// Shared restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on dcpu_pkg.
module dcpu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         dividend,
	input  logic [15:0]         divisor,
	output dcpu_pkg::div_ctrl_t ctrl,
	output logic [31:0]         quotient,
	output logic [15:0]         remainder
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], quo_q[31]} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign ctrl.start = start;
	assign ctrl.busy = busy_q;
	assign ctrl.done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q[15:0];
endmodule

/* tb/tb_types.sv */
`timescale 1ns / 1ps
// Payload types of the execute unit's input and result channels.
// Depends on dcpu_pkg for the data and opcode widths.
package tb_types;
	typedef struct packed {
		logic [dcpu_pkg::OpWidth-1:0]   opcode;
		logic [dcpu_pkg::DataWidth-1:0] b_value;
		logic [dcpu_pkg::DataWidth-1:0] a_value;
	} exec_in_t;

	typedef struct packed {
		logic [dcpu_pkg::DataWidth-1:0] new_b;
		logic                           write_b;
		logic [dcpu_pkg::DataWidth-1:0] ex_out;
		logic [1:0]                     index_step;
		logic                           was_skipped;
	} exec_out_t;
endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for dcpu16_execute_unit_top: directed and random
// instructions, a local predictor of EX and skip state. Depends on dcpu_pkg,
// dcpu_if, tb_types and the RTL.
module tb_top;
	localparam int RandomItems = 1800;
	localparam int CycleLimit = 600000;
	localparam int QuietFrom = 2000, QuietTo = 4000;     // no idling on either side
	localparam int HoldFrom = 6000, HoldLen = 400;       // long receiver hold-off

	// an item plus a flag telling the driver to wait for the pipe to empty first
	typedef struct {
		tb_types::exec_in_t item;
		bit                 drain_first;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dcpu_if #(.payload_t(tb_types::exec_in_t))  in_ch();
	dcpu_if #(.payload_t(tb_types::exec_out_t)) out_ch();

	dcpu16_execute_unit_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	pending_t  pending_q[$];
	tb_types::exec_out_t expected_q[$];
	logic [15:0] ex_model = '0;
	bit          skip_model = 1'b0;
	int cycle_cnt = 0;
	int mismatch_cnt = 0;
	int checked_cnt = 0;
	int skipped_cnt = 0;
	int divide_cnt = 0;
	int hold_left = 0;
	bit in_taken = 1'b0;

	// Advance the predictor by one instruction and return the expected result.
	function automatic tb_types::exec_out_t execute_predict(tb_types::exec_in_t it);
		tb_types::exec_out_t r;
		logic [15:0] b, a;
		logic signed [15:0] sb, sa;
		logic [16:0] sum;
		logic [31:0] prod, sh32;
		logic signed [31:0] sx;
		logic [63:0] sh64;
		longint q;
		int sh;
		bit is_if;
		b = it.b_value;
		a = it.a_value;
		sb = b;
		sa = a;
		is_if = (it.opcode >= dcpu_pkg::OP_IFB) && (it.opcode <= dcpu_pkg::OP_IFU);
		r.new_b = b;
		r.write_b = 1'b0;
		r.index_step = dcpu_pkg::STEP_NONE;
		r.was_skipped = 1'b0;
		sh = (a > 32) ? 32 : int'(a);
		if (skip_model) begin
			r.was_skipped = 1'b1;
			if (!is_if)
				skip_model = 1'b0;
		end else begin
			case (it.opcode)
				dcpu_pkg::OP_SET: begin r.new_b = a; r.write_b = 1'b1; end
				dcpu_pkg::OP_ADD: begin
					sum = {1'b0, b} + {1'b0, a};
					r.new_b = sum[15:0]; r.write_b = 1'b1;
					ex_model = {15'd0, sum[16]};
				end
				dcpu_pkg::OP_SUB: begin
					r.new_b = b - a; r.write_b = 1'b1;
					ex_model = (b < a) ? 16'hFFFF : 16'h0000;
				end
				dcpu_pkg::OP_MUL: begin
					prod = b * a;
					r.new_b = prod[15:0]; r.write_b = 1'b1; ex_model = prod[31:16];
				end
				dcpu_pkg::OP_MLI: begin
					prod = 32'(int'(sb) * int'(sa));
					r.new_b = prod[15:0]; r.write_b = 1'b1; ex_model = prod[31:16];
				end
				dcpu_pkg::OP_DIV: begin
					r.write_b = 1'b1;
					if (a == 0)
						r.new_b = '0;
					else begin
						ex_model = 16'(({b, 16'h0}) / a);
						r.new_b = b / a;
					end
				end
				dcpu_pkg::OP_DVI: begin
					r.write_b = 1'b1;
					if (sa == 0)
						r.new_b = '0;
					else begin
						q = (longint'(sb) * 65536) / longint'(sa);
						ex_model = q[15:0];
						q = longint'(sb) / longint'(sa);
						r.new_b = q[15:0];
					end
				end
				dcpu_pkg::OP_MOD: begin
					r.write_b = 1'b1; r.new_b = (a == 0) ? 16'h0 : b % a;
				end
				dcpu_pkg::OP_MDI: begin
					r.write_b = 1'b1;
					if (sa == 0)
						r.new_b = '0;
					else begin
						q = longint'(sb) % longint'(sa);
						r.new_b = q[15:0];
					end
				end
				dcpu_pkg::OP_AND: begin r.write_b = 1'b1; r.new_b = b & a; end
				dcpu_pkg::OP_BOR: begin r.write_b = 1'b1; r.new_b = b | a; end
				dcpu_pkg::OP_XOR: begin r.write_b = 1'b1; r.new_b = b ^ a; end
				dcpu_pkg::OP_SHR: begin
					sh32 = (sh >= 32) ? 32'h0 : ({b, 16'h0} >> sh);
					r.write_b = 1'b1; r.new_b = sh32[31:16]; ex_model = sh32[15:0];
				end
				dcpu_pkg::OP_ASR: begin
					sx = {b, 16'h0};
					sx = sx >>> ((sh > 31) ? 31 : sh);
					r.write_b = 1'b1; r.new_b = sx[31:16]; ex_model = sx[15:0];
				end
				dcpu_pkg::OP_SHL: begin
					sh64 = {48'h0, b} << sh;
					r.write_b = 1'b1; r.new_b = sh64[15:0]; ex_model = sh64[31:16];
				end
				dcpu_pkg::OP_IFB: skip_model = !((b & a) != 0);
				dcpu_pkg::OP_IFC: skip_model = !((b & a) == 0);
				dcpu_pkg::OP_IFE: skip_model = !(b == a);
				dcpu_pkg::OP_IFN: skip_model = !(b != a);
				dcpu_pkg::OP_IFG: skip_model = !(b > a);
				dcpu_pkg::OP_IFA: skip_model = !(sb > sa);
				dcpu_pkg::OP_IFL: skip_model = !(b < a);
				dcpu_pkg::OP_IFU: skip_model = !(sb < sa);
				dcpu_pkg::OP_STI: begin
					r.write_b = 1'b1; r.new_b = a; r.index_step = dcpu_pkg::STEP_INC;
				end
				dcpu_pkg::OP_STD: begin
					r.write_b = 1'b1; r.new_b = a; r.index_step = dcpu_pkg::STEP_DEC;
				end
				default: ;
			endcase
		end
		r.ex_out = ex_model;
		return r;
	endfunction

	// Operand values leaning on the corners: zero, all ones, sign edges, shift counts.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(0, 40));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_item(logic [4:0] op, logic [15:0] b, logic [15:0] a, bit drain);
		pending_t p;
		p.item.opcode = op;
		p.item.b_value = b;
		p.item.a_value = a;
		p.drain_first = drain;
		pending_q.push_back(p);
	endtask

	// Driver: present items at the falling edge, idle now and then.
	always @(negedge clk) begin
		bit quiet, give;
		quiet = (cycle_cnt >= QuietFrom) && (cycle_cnt < QuietTo);
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_taken) begin
			give = pending_q.size() > 0;
			if (give && pending_q[0].drain_first && (expected_q.size() > 0 || in_taken))
				give = 1'b0;
			if (give && !quiet && $urandom_range(0, 99) < 10)
				give = 1'b0;
			if (give) begin
				in_ch.data <= pending_q[0].item;
				pending_q.pop_front();
			end
			in_ch.valid <= give;
		end
	end

	// Receiver: random stalls, a quiet window and one long hold-off.
	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else begin
			if (cycle_cnt == HoldFrom)
				hold_left = HoldLen;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ch.ready <= 1'b0;
			end else if (cycle_cnt >= QuietFrom && cycle_cnt < QuietTo)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 99) >= 10);
		end
	end

	// Monitor: predict on accepted items, check accepted results.
	always @(posedge clk) begin
		tb_types::exec_out_t exp_r, got;
		cycle_cnt <= cycle_cnt + 1;
		in_taken <= in_ch.valid && in_ch.ready;
		if (in_ch.valid && in_ch.ready) begin
			expected_q.push_back(execute_predict(in_ch.data));
			if (in_ch.data.opcode inside {dcpu_pkg::OP_DIV, dcpu_pkg::OP_DVI,
					dcpu_pkg::OP_MOD, dcpu_pkg::OP_MDI})
				divide_cnt <= divide_cnt + 1;
		end
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			checked_cnt <= checked_cnt + 1;
			if (got.was_skipped === 1'b1)
				skipped_cnt <= skipped_cnt + 1;
			if (expected_q.size() == 0) begin
				mismatch_cnt = mismatch_cnt + 1;
				if (mismatch_cnt <= 10)
					$display("unexpected result %p at cycle %0d", got, cycle_cnt);
			end else begin
				exp_r = expected_q.pop_front();
				if (got.new_b !== exp_r.new_b || got.write_b !== exp_r.write_b ||
						got.ex_out !== exp_r.ex_out || got.index_step !== exp_r.index_step ||
						got.was_skipped !== exp_r.was_skipped) begin
					mismatch_cnt = mismatch_cnt + 1;
					if (mismatch_cnt <= 10)
						$display("mismatch at cycle %0d: expected %p, got %p",
							cycle_cnt, exp_r, got);
				end
			end
		end
		if (cycle_cnt >= CycleLimit) begin
			$display("timeout at cycle %0d", cycle_cnt);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int n;
		logic [4:0] op;

		// directed: most opcodes at their corners, borrow, divide by zero, overflowing
		// DVI, saturating shifts, failed IFs chained and an unused opcode
		queue_item(5'h00, 16'h1234, 16'h5678, 0);
		queue_item(dcpu_pkg::OP_SET, 16'h0000, 16'hFFFF, 0);
		queue_item(dcpu_pkg::OP_ADD, 16'hFFFF, 16'h0001, 0);
		queue_item(dcpu_pkg::OP_SUB, 16'h0000, 16'h0001, 0);
		queue_item(dcpu_pkg::OP_MUL, 16'hFFFF, 16'hFFFF, 0);
		queue_item(dcpu_pkg::OP_MLI, 16'h8000, 16'hFFFF, 0);
		queue_item(dcpu_pkg::OP_DIV, 16'h1234, 16'h0000, 0);
		queue_item(dcpu_pkg::OP_DVI, 16'h8000, 16'hFFFF, 0);
		queue_item(dcpu_pkg::OP_DVI, 16'hFFF9, 16'h0002, 0);
		queue_item(dcpu_pkg::OP_MOD, 16'hFFFF, 16'h0000, 0);
		queue_item(dcpu_pkg::OP_MDI, 16'hFFF9, 16'h0002, 0);
		queue_item(dcpu_pkg::OP_AND, 16'hF0F0, 16'hFF00, 0);
		queue_item(dcpu_pkg::OP_BOR, 16'hF0F0, 16'h0F0F, 0);
		queue_item(dcpu_pkg::OP_XOR, 16'hFFFF, 16'hAAAA, 0);
		queue_item(dcpu_pkg::OP_SHR, 16'hFFFF, 16'h0010, 0);
		queue_item(dcpu_pkg::OP_ASR, 16'h8001, 16'hFFFF, 0);
		queue_item(dcpu_pkg::OP_SHL, 16'hFFFF, 16'h0020, 0);
		queue_item(dcpu_pkg::OP_IFE, 16'h0001, 16'h0002, 1);
		queue_item(dcpu_pkg::OP_IFN, 16'h0001, 16'h0001, 0);
		queue_item(dcpu_pkg::OP_IFB, 16'h0000, 16'hFFFF, 0);
		queue_item(dcpu_pkg::OP_ADD, 16'h0001, 16'h0001, 0);
		queue_item(dcpu_pkg::OP_IFC, 16'h0001, 16'h0001, 0);
		queue_item(dcpu_pkg::OP_STI, 16'h0000, 16'hBEEF, 0);
		queue_item(dcpu_pkg::OP_STD, 16'hFFFF, 16'h0000, 0);
		queue_item(dcpu_pkg::OP_IFU, 16'h7FFF, 16'h8000, 0);

		// random: mostly real opcodes, IF runs to build skip chains
		n = 0;
		while (n < RandomItems) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					queue_item(5'($urandom_range(dcpu_pkg::OP_IFB, dcpu_pkg::OP_IFU)),
						pick_operand(), pick_operand(), 0);
					n++;
				end
			end
			op = 5'($urandom);
			queue_item(op, pick_operand(), pick_operand(), n == 900);
			n++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0);
		@(posedge clk);
		while (in_ch.valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d results, %0d skipped, %0d divide-type instructions",
			checked_cnt, skipped_cnt, divide_cnt);
		if (mismatch_cnt == 0 && expected_q.size() == 0)
			$display("tb: success");
		else begin
			$display("%0d mismatches", mismatch_cnt);
			$display("tb: failure");
		end
		$finish;
	end
endmodule

/* dcpu16_execute_unit_top.f */
design/dcpu_pkg.sv
design/dcpu_if.sv
design/dcpu_div.sv
design/dcpu16_execute_unit_top.sv
tb/tb_types.sv
tb/tb_top.sv
